// ----- rtl/core/byte_stack_machine_step_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef BYTE_STACK_MACHINE_STEP_MACROS_SVH
`define BYTE_STACK_MACHINE_STEP_MACROS_SVH

// same-cycle implication, held off during reset
`define BSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define BSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/bsm_pkg.sv -----
// Package: opcodes, status codes, sequencer states and decode tables.
package bsm_pkg;

  localparam logic [5:0] OP_PUSH    = 6'd0;
  localparam logic [5:0] OP_PUSH32  = 6'd1;
  localparam logic [5:0] OP_POPA8   = 6'd2;
  localparam logic [5:0] OP_POPA32  = 6'd3;
  localparam logic [5:0] OP_SUB8    = 6'd4;
  localparam logic [5:0] OP_ADD32   = 6'd5;
  localparam logic [5:0] OP_ADD8    = 6'd6;
  localparam logic [5:0] OP_SUB32   = 6'd7;
  localparam logic [5:0] OP_MUL8    = 6'd8;
  localparam logic [5:0] OP_MUL32   = 6'd9;
  localparam logic [5:0] OP_DIV8    = 6'd10;
  localparam logic [5:0] OP_DIV32   = 6'd11;
  localparam logic [5:0] OP_CMP     = 6'd12;
  localparam logic [5:0] OP_CMP32   = 6'd13;
  localparam logic [5:0] OP_SWAP8   = 6'd14;
  localparam logic [5:0] OP_SWAP32  = 6'd15;
  localparam logic [5:0] OP_PUTC    = 6'd16;
  localparam logic [5:0] OP_JE      = 6'd17;
  localparam logic [5:0] OP_JL      = 6'd18;
  localparam logic [5:0] OP_JG      = 6'd19;
  localparam logic [5:0] OP_JNE     = 6'd20;
  localparam logic [5:0] OP_JMP     = 6'd21;
  localparam logic [5:0] OP_PUSHA32 = 6'd22;
  localparam logic [5:0] OP_PUSHA8  = 6'd23;
  localparam logic [5:0] OP_DUP32   = 6'd24;
  localparam logic [5:0] OP_DUP8    = 6'd25;
  localparam logic [5:0] OP_POPB8   = 6'd26;
  localparam logic [5:0] OP_POPB32  = 6'd27;
  localparam logic [5:0] OP_PUSHB32 = 6'd28;
  localparam logic [5:0] OP_PUSHB8  = 6'd29;
  localparam logic [5:0] OP_MK4     = 6'd30;
  localparam logic [5:0] OP_MK1     = 6'd31;
  localparam logic [5:0] OP_STORE   = 6'd32;
  localparam logic [5:0] OP_LOAD    = 6'd33;
  localparam logic [5:0] OP_LOAD32  = 6'd34;
  localparam logic [5:0] OP_STORE32 = 6'd35;
  localparam logic [5:0] OP_COUNT   = 6'd36;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNDER   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_DIV0    = 3'd4;
  localparam logic [2:0] ST_FAULTED = 3'd5;

  localparam logic [7:0] CMP_EQ = 8'd1;
  localparam logic [7:0] CMP_GT = 8'd2;
  localparam logic [7:0] CMP_LT = 8'd3;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_RD_ADDR, S_RD_DATA, S_CHECK, S_DIV,
    S_LD_ADDR, S_LD_DATA, S_ST, S_EXEC, S_PUSH, S_FINISH
  } state_t;

  // bytes popped per opcode
  function automatic logic [3:0] pop_count(input logic [5:0] op);
    logic [3:0] r;
    unique case (op)
      OP_POPA8, OP_PUTC, OP_DUP8, OP_POPB8:                     r = 4'd1;
      OP_SUB8, OP_ADD8, OP_MUL8, OP_DIV8, OP_CMP, OP_SWAP8:     r = 4'd2;
      OP_POPA32, OP_JMP, OP_DUP32, OP_POPB32, OP_MK1,
      OP_LOAD, OP_LOAD32:                                       r = 4'd4;
      OP_STORE:                                                 r = 4'd5;
      OP_ADD32, OP_SUB32, OP_MUL32, OP_DIV32, OP_CMP32,
      OP_SWAP32, OP_JE, OP_JL, OP_JG, OP_JNE, OP_STORE32:       r = 4'd8;
      default:                                                  r = 4'd0;
    endcase
    return r;
  endfunction

  // bytes pushed per opcode
  function automatic logic [3:0] push_count(input logic [5:0] op);
    logic [3:0] r;
    unique case (op)
      OP_PUSH, OP_SUB8, OP_ADD8, OP_MUL8, OP_DIV8, OP_CMP, OP_CMP32,
      OP_PUSHA8, OP_PUSHB8, OP_LOAD:                            r = 4'd1;
      OP_SWAP8, OP_DUP8:                                        r = 4'd2;
      OP_MK4:                                                   r = 4'd3;
      OP_PUSH32, OP_ADD32, OP_SUB32, OP_MUL32, OP_DIV32,
      OP_PUSHA32, OP_PUSHB32, OP_LOAD32:                        r = 4'd4;
      OP_SWAP32, OP_DUP32:                                      r = 4'd8;
      default:                                                  r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cmp_code(input logic [31:0] t, input logic [31:0] n);
    logic [7:0] r;
    if (t == n) r = CMP_EQ;
    else if (t > n) r = CMP_GT;
    else r = CMP_LT;
    return r;
  endfunction

endpackage

// ----- rtl/core/bsm_ram.sv -----
// Generic single-port RAM with registered read.
module bsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/bsm_div.sv -----
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module bsm_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[31]};
    diff     = shifted - {1'b0, dvs_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/core/byte_stack_machine_step.sv -----
// Top level: byte stack machine that executes one instruction per transfer.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_op, in_immediate
//   out_     output     out_valid/out_stall next_pc, char_valid, char_byte, status, reg A/B
//
// Steps: one instruction at a time; decode, a read address and read data state
// per popped byte, check, the divider for DIV8/DIV32, an address and data state
// per loaded byte or a state per stored byte, execute, a state per pushed byte,
// finish. Stack bytes and data memory go through single-port RAMs, one byte per access.
// Reset: synchronous; the data memory is then zeroed one byte a cycle, and
// the input stalls after reset until every byte has been cleared.
// Stalls: a finished result waits in the output register; the next
// instruction is taken meanwhile and holds in its last state until the
// output transfer frees the register.
module byte_stack_machine_step #(
  parameter int STACK_BYTES = 256,
  parameter int MEM_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_op,
  input  logic [31:0] in_immediate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_next_pc,
  output logic        out_char_valid,
  output logic [7:0]  out_char_byte,
  output logic [2:0]  out_status,
  output logic [31:0] out_reg_a_value,
  output logic [31:0] out_reg_b_value
);

  localparam int SA_W = $clog2(STACK_BYTES);
  localparam int SP_W = $clog2(STACK_BYTES + 1);
  localparam int MA_W = $clog2(MEM_BYTES);

  bsm_pkg::state_t state_r, state_nxt;

  logic [5:0]      op_r, op_nxt;
  logic [31:0]     imm_r, imm_nxt;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic [31:0]     reg_a_r, reg_a_nxt;
  logic [31:0]     reg_b_r, reg_b_nxt;
  logic [31:0]     pc_r, pc_nxt;
  logic            fault_r, fault_nxt;
  logic [3:0]      k_r, k_nxt;
  logic [7:0]      pop_r [8];
  logic [7:0]      pop_nxt [8];
  logic [31:0]     ld_r, ld_nxt;
  logic [63:0]     pv_r, pv_nxt;
  logic [2:0]      status_r, status_nxt;
  logic [31:0]     npc_r, npc_nxt;
  logic            cv_r, cv_nxt;
  logic [7:0]      cb_r, cb_nxt;
  logic [MA_W-1:0] clr_r, clr_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [31:0]     out_npc_r;
  logic            out_cv_r;
  logic [7:0]      out_cb_r;
  logic [2:0]      out_status_r;
  logic [31:0]     out_a_r;
  logic [31:0]     out_b_r;
  logic            out_load;

  // stack RAM
  logic            stk_we;
  logic [SA_W-1:0] stk_addr;
  logic [7:0]      stk_wdata;
  logic [7:0]      stk_rdata;

  // data RAM
  logic            dm_we;
  logic [MA_W-1:0] dm_addr;
  logic [7:0]      dm_wdata;
  logic [7:0]      dm_rdata;

  // divider
  logic            div_start;
  logic            div_done;
  logic [31:0]     div_q;
  logic [31:0]     div_a;
  logic [31:0]     div_b;

  // operand views of the popped bytes (byte 0 is the old top of stack)
  logic [3:0]      np, nu;
  logic [7:0]      tb, nb;
  logic [31:0]     t, n;
  logic [SP_W-1:0] base;
  logic            underflow, overflow;
  logic [3:0]      mem_w;
  logic            range_err, div_zero;
  logic            is_div, is_load, is_store;
  logic [SP_W-1:0] rd_pos;
  logic [SP_W-1:0] wr_pos;
  logic [MA_W-1:0] mem_addr;
  logic [7:0]      add8, sub8, mul8;
  logic [31:0]     mul32;

  assign np   = bsm_pkg::pop_count(op_r);
  assign nu   = bsm_pkg::push_count(op_r);
  assign tb   = pop_r[0];
  assign nb   = (op_r == bsm_pkg::OP_STORE) ? pop_r[4] : pop_r[1];
  assign t    = {pop_r[0], pop_r[1], pop_r[2], pop_r[3]};
  assign n    = {pop_r[4], pop_r[5], pop_r[6], pop_r[7]};
  assign base = sp_r - SP_W'(np);

  assign underflow = sp_r < SP_W'(np);
  assign overflow  = ({1'b0, base} + (SP_W+1)'(nu)) > (SP_W+1)'(STACK_BYTES);

  assign is_div   = (op_r == bsm_pkg::OP_DIV8) || (op_r == bsm_pkg::OP_DIV32);
  assign is_load  = (op_r == bsm_pkg::OP_LOAD) || (op_r == bsm_pkg::OP_LOAD32);
  assign is_store = (op_r == bsm_pkg::OP_STORE) || (op_r == bsm_pkg::OP_STORE32);
  assign mem_w    = ((op_r == bsm_pkg::OP_LOAD) || (op_r == bsm_pkg::OP_STORE)) ?
                    4'd1 : 4'd4;
  // access must fit entirely, whole width
  assign range_err = (is_load || is_store) &&
                     (({1'b0, t} + 33'(mem_w)) > 33'(MEM_BYTES));
  assign div_zero  = ((op_r == bsm_pkg::OP_DIV8) && (nb == 8'd0)) ||
                     ((op_r == bsm_pkg::OP_DIV32) && (n == 32'd0));

  assign rd_pos   = sp_r - SP_W'(1) - SP_W'(k_r);
  assign wr_pos   = base + SP_W'(k_r);
  assign mem_addr = t[MA_W-1:0] + MA_W'(k_r);

  assign div_a = (op_r == bsm_pkg::OP_DIV8) ? {24'd0, tb} : t;
  assign div_b = (op_r == bsm_pkg::OP_DIV8) ? {24'd0, nb} : n;

  assign add8  = tb + nb;
  assign sub8  = tb - nb;
  assign mul8  = tb * nb;
  assign mul32 = t * n;

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    imm_nxt    = imm_r;
    sp_nxt     = sp_r;
    reg_a_nxt  = reg_a_r;
    reg_b_nxt  = reg_b_r;
    pc_nxt     = pc_r;
    fault_nxt  = fault_r;
    k_nxt      = k_r;
    pop_nxt    = pop_r;
    ld_nxt     = ld_r;
    pv_nxt     = pv_r;
    status_nxt = status_r;
    npc_nxt    = npc_r;
    cv_nxt     = cv_r;
    cb_nxt     = cb_r;
    clr_nxt    = clr_r;
    out_load   = 1'b0;
    stk_we     = 1'b0;
    stk_addr   = rd_pos[SA_W-1:0];
    stk_wdata  = pv_r[7:0];
    dm_we      = 1'b0;
    dm_addr    = mem_addr;
    dm_wdata   = 8'd0;
    div_start  = 1'b0;

    unique case (state_r)
      bsm_pkg::S_CLEAR: begin
        dm_we    = 1'b1;
        dm_addr  = clr_r;
        dm_wdata = 8'd0;
        clr_nxt  = clr_r + MA_W'(1);
        if (clr_r == MA_W'(MEM_BYTES - 1)) begin
          state_nxt = bsm_pkg::S_IDLE;
        end
      end
      bsm_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          imm_nxt   = in_immediate;
          state_nxt = bsm_pkg::S_DECODE;
        end
      end
      bsm_pkg::S_DECODE: begin
        k_nxt      = '0;
        npc_nxt    = pc_r + 32'd1;
        cv_nxt     = 1'b0;
        cb_nxt     = 8'd0;
        status_nxt = bsm_pkg::ST_OK;
        priority if (fault_r) begin
          status_nxt = bsm_pkg::ST_FAULTED;
          npc_nxt    = pc_r;
          state_nxt  = bsm_pkg::S_FINISH;
        end else if (op_r >= bsm_pkg::OP_COUNT) begin
          state_nxt = bsm_pkg::S_FINISH;
        end else if (underflow) begin
          status_nxt = bsm_pkg::ST_UNDER;
          npc_nxt    = pc_r;
          state_nxt  = bsm_pkg::S_FINISH;
        end else if (overflow) begin
          status_nxt = bsm_pkg::ST_OVER;
          npc_nxt    = pc_r;
          state_nxt  = bsm_pkg::S_FINISH;
        end else if (np == 4'd0) begin
          state_nxt = bsm_pkg::S_CHECK;
        end else begin
          state_nxt = bsm_pkg::S_RD_ADDR;
        end
      end
      bsm_pkg::S_RD_ADDR: begin
        stk_addr  = rd_pos[SA_W-1:0];
        state_nxt = bsm_pkg::S_RD_DATA;
      end
      bsm_pkg::S_RD_DATA: begin
        pop_nxt[k_r[2:0]] = stk_rdata;
        k_nxt = k_r + 4'd1;
        state_nxt = (k_r + 4'd1 == np) ? bsm_pkg::S_CHECK : bsm_pkg::S_RD_ADDR;
      end
      bsm_pkg::S_CHECK: begin
        k_nxt = '0;
        priority if (range_err) begin
          status_nxt = bsm_pkg::ST_RANGE;
          npc_nxt    = pc_r;
          state_nxt  = bsm_pkg::S_FINISH;
        end else if (div_zero) begin
          status_nxt = bsm_pkg::ST_DIV0;
          npc_nxt    = pc_r;
          state_nxt  = bsm_pkg::S_FINISH;
        end else if (is_div) begin
          div_start = 1'b1;
          state_nxt = bsm_pkg::S_DIV;
        end else if (is_load) begin
          state_nxt = bsm_pkg::S_LD_ADDR;
        end else if (is_store) begin
          state_nxt = bsm_pkg::S_ST;
        end else begin
          state_nxt = bsm_pkg::S_EXEC;
        end
      end
      bsm_pkg::S_DIV: begin
        if (div_done) begin
          state_nxt = bsm_pkg::S_EXEC;
        end
      end
      bsm_pkg::S_LD_ADDR: begin
        dm_addr   = mem_addr;
        state_nxt = bsm_pkg::S_LD_DATA;
      end
      bsm_pkg::S_LD_DATA: begin
        ld_nxt[{k_r[1:0], 3'b000} +: 8] = dm_rdata;
        k_nxt = k_r + 4'd1;
        state_nxt = (k_r + 4'd1 == mem_w) ? bsm_pkg::S_EXEC : bsm_pkg::S_LD_ADDR;
      end
      bsm_pkg::S_ST: begin
        dm_we    = 1'b1;
        dm_addr  = mem_addr;
        dm_wdata = (op_r == bsm_pkg::OP_STORE) ? nb : n[{k_r[1:0], 3'b000} +: 8];
        k_nxt    = k_r + 4'd1;
        if (k_r + 4'd1 == mem_w) begin
          state_nxt = bsm_pkg::S_EXEC;
        end
      end
      bsm_pkg::S_EXEC: begin
        k_nxt  = '0;
        pv_nxt = '0;
        unique case (op_r)
          bsm_pkg::OP_PUSH:    pv_nxt = {56'd0, imm_r[7:0]};
          bsm_pkg::OP_PUSH32:  pv_nxt = {32'd0, imm_r};
          bsm_pkg::OP_POPA8:   reg_a_nxt = {24'd0, tb};
          bsm_pkg::OP_POPA32:  reg_a_nxt = t;
          bsm_pkg::OP_SUB8:    pv_nxt = {56'd0, sub8};
          bsm_pkg::OP_ADD32:   pv_nxt = {32'd0, t + n};
          bsm_pkg::OP_ADD8:    pv_nxt = {56'd0, add8};
          bsm_pkg::OP_SUB32:   pv_nxt = {32'd0, t - n};
          bsm_pkg::OP_MUL8:    pv_nxt = {56'd0, mul8};
          bsm_pkg::OP_MUL32:   pv_nxt = {32'd0, mul32};
          bsm_pkg::OP_DIV8:    pv_nxt = {56'd0, div_q[7:0]};
          bsm_pkg::OP_DIV32:   pv_nxt = {32'd0, div_q};
          bsm_pkg::OP_CMP:     pv_nxt = {56'd0, bsm_pkg::cmp_code({24'd0, tb}, {24'd0, nb})};
          bsm_pkg::OP_CMP32:   pv_nxt = {56'd0, bsm_pkg::cmp_code(t, n)};
          bsm_pkg::OP_SWAP8:   pv_nxt = {48'd0, nb, tb};
          bsm_pkg::OP_SWAP32:  pv_nxt = {n, t};
          bsm_pkg::OP_PUTC: begin
            cv_nxt = 1'b1;
            cb_nxt = tb;
          end
          bsm_pkg::OP_JE:      if (n == 32'd1) npc_nxt = t;
          bsm_pkg::OP_JL:      if (n == 32'd3) npc_nxt = t;
          bsm_pkg::OP_JG:      if (n == 32'd2) npc_nxt = t;
          bsm_pkg::OP_JNE:     if (n != 32'd1) npc_nxt = t;
          bsm_pkg::OP_JMP:     npc_nxt = t;
          bsm_pkg::OP_PUSHA32: pv_nxt = {32'd0, reg_a_r};
          bsm_pkg::OP_PUSHA8:  pv_nxt = {56'd0, reg_a_r[7:0]};
          bsm_pkg::OP_DUP32:   pv_nxt = {t, t};
          bsm_pkg::OP_DUP8:    pv_nxt = {48'd0, tb, tb};
          bsm_pkg::OP_POPB8:   reg_b_nxt = {24'd0, tb};
          bsm_pkg::OP_POPB32:  reg_b_nxt = t;
          bsm_pkg::OP_PUSHB32: pv_nxt = {32'd0, reg_b_r};
          bsm_pkg::OP_PUSHB8:  pv_nxt = {56'd0, reg_b_r[7:0]};
          bsm_pkg::OP_LOAD:    pv_nxt = {56'd0, ld_r[7:0]};
          bsm_pkg::OP_LOAD32:  pv_nxt = {32'd0, ld_r};
          default:             pv_nxt = '0;  // MK4 pushes zeros; others push nothing
        endcase
        state_nxt = (nu == 4'd0) ? bsm_pkg::S_FINISH : bsm_pkg::S_PUSH;
      end
      bsm_pkg::S_PUSH: begin
        stk_we    = 1'b1;
        stk_addr  = wr_pos[SA_W-1:0];
        stk_wdata = pv_r[{k_r[2:0], 3'b000} +: 8];
        k_nxt     = k_r + 4'd1;
        if (k_r + 4'd1 == nu) begin
          state_nxt = bsm_pkg::S_FINISH;
        end
      end
      bsm_pkg::S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          pc_nxt   = npc_r;
          if (status_r == bsm_pkg::ST_OK) begin
            sp_nxt = base + SP_W'(nu);
          end else if (status_r != bsm_pkg::ST_FAULTED) begin
            fault_nxt = 1'b1;
          end
          state_nxt = bsm_pkg::S_IDLE;
        end
      end
      default: state_nxt = bsm_pkg::S_IDLE;
    endcase
  end

  // output register: held while stalled, freed by a transfer
  assign out_valid_nxt = out_load | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsm_pkg::S_CLEAR;
      clr_r       <= '0;
      sp_r        <= '0;
      reg_a_r     <= '0;
      reg_b_r     <= '0;
      pc_r        <= '0;
      fault_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      sp_r        <= sp_nxt;
      reg_a_r     <= reg_a_nxt;
      reg_b_r     <= reg_b_nxt;
      pc_r        <= pc_nxt;
      fault_r     <= fault_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r     <= op_nxt;
    imm_r    <= imm_nxt;
    pop_r    <= pop_nxt;
    ld_r     <= ld_nxt;
    pv_r     <= pv_nxt;
    status_r <= status_nxt;
    npc_r    <= npc_nxt;
    cv_r     <= cv_nxt;
    cb_r     <= cb_nxt;
    if (out_load) begin
      out_npc_r    <= npc_r;
      out_cv_r     <= cv_r;
      out_cb_r     <= cb_r;
      out_status_r <= status_r;
      out_a_r      <= reg_a_r;
      out_b_r      <= reg_b_r;
    end
  end

  bsm_ram #(
    .WIDTH (8),
    .DEPTH (STACK_BYTES)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .addr  (stk_addr),
    .wdata (stk_wdata),
    .rdata (stk_rdata)
  );

  bsm_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_data_ram (
    .clk   (clk),
    .we    (dm_we),
    .addr  (dm_addr),
    .wdata (dm_wdata),
    .rdata (dm_rdata)
  );

  bsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall        = (state_r != bsm_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_npc_r;
  assign out_char_valid  = out_cv_r;
  assign out_char_byte   = out_cb_r;
  assign out_status      = out_status_r;
  assign out_reg_a_value = out_a_r;
  assign out_reg_b_value = out_b_r;

endmodule

// ----- rtl/core/bsm_checker.sv -----
// Port-level checker for the stack machine, bound to the top level.
`include "byte_stack_machine_step_macros.svh"

module bsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_next_pc,
  input logic        out_char_valid,
  input logic [7:0]  out_char_byte,
  input logic [2:0]  out_status
);

  `BSM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  `BSM_ASSERT_NEXT(a_pc_hold, out_valid && out_stall, $stable(out_next_pc), "next_pc moved while stalled")
  `BSM_ASSERT_NOW(a_char_ok, out_valid && out_char_valid, out_status == bsm_pkg::ST_OK, "char on failed step")
  `BSM_ASSERT_NOW(a_char_zero, out_valid && !out_char_valid, out_char_byte == 8'd0, "stray char byte")

endmodule

bind byte_stack_machine_step bsm_checker u_bsm_checker (.*);

// ----- test/byte_stack_machine_step_checker.sv -----
// Checker: watches both channels, predicts each step and compares results.
module byte_stack_machine_step_checker
  import bsm_pkg::*;
#(
  parameter int STACK_BYTES = 256,
  parameter int MEM_BYTES   = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [5:0]  in_op,
  input  logic [31:0] in_immediate,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_next_pc,
  input  logic        out_char_valid,
  input  logic [7:0]  out_char_byte,
  input  logic [2:0]  out_status,
  input  logic [31:0] out_reg_a_value,
  input  logic [31:0] out_reg_b_value,
  output int          fail_count,
  output int          pending_count,
  output int          stack_depth,
  output logic        faulted
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        char_valid;
    logic [7:0]  char_byte;
    logic [2:0]  status;
    logic [31:0] reg_a;
    logic [31:0] reg_b;
  } step_result_t;

  logic [7:0]  stk [STACK_BYTES];
  logic [7:0]  mem [MEM_BYTES];
  int          sp;
  logic [31:0] ra, rb, pc;
  step_result_t expected_steps[$];

  function automatic logic [31:0] word_below(int top_end);
    return {stk[top_end-1], stk[top_end-2], stk[top_end-3], stk[top_end-4]};
  endfunction

  function automatic void put_word(int at, logic [31:0] v);
    for (int i = 0; i < 4; i++) stk[at+i] = v[8*i +: 8];
  endfunction

  function automatic int pops_of(logic [5:0] op);
    case (op)
      OP_POPA8, OP_PUTC, OP_DUP8, OP_POPB8: return 1;
      OP_SUB8, OP_ADD8, OP_MUL8, OP_DIV8, OP_CMP, OP_SWAP8: return 2;
      OP_POPA32, OP_JMP, OP_DUP32, OP_POPB32, OP_MK1, OP_LOAD, OP_LOAD32: return 4;
      OP_STORE: return 5;
      OP_ADD32, OP_SUB32, OP_MUL32, OP_DIV32, OP_CMP32, OP_SWAP32,
      OP_JE, OP_JL, OP_JG, OP_JNE, OP_STORE32: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic int pushes_of(logic [5:0] op);
    case (op)
      OP_PUSH, OP_SUB8, OP_ADD8, OP_MUL8, OP_DIV8, OP_CMP, OP_CMP32,
      OP_PUSHA8, OP_PUSHB8, OP_LOAD: return 1;
      OP_SWAP8, OP_DUP8: return 2;
      OP_MK4: return 3;
      OP_PUSH32, OP_ADD32, OP_SUB32, OP_MUL32, OP_DIV32, OP_PUSHA32,
      OP_PUSHB32, OP_LOAD32: return 4;
      OP_SWAP32, OP_DUP32: return 8;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] order_code(logic [31:0] t, logic [31:0] n);
    if (t == n) return CMP_EQ;
    return (t > n) ? CMP_GT : CMP_LT;
  endfunction

  // executes one instruction on the shadow machine
  function automatic step_result_t execute_step(logic [5:0] op, logic [31:0] imm);
    step_result_t r;
    int np, nu, base;
    logic [31:0] t, n;
    logic [7:0] tb, nb;
    r = '0;
    r.next_pc = pc + 1;
    t = '0; n = '0; tb = '0; nb = '0;
    if (faulted) begin
      r.status = ST_FAULTED;
      r.next_pc = pc;
    end else if (op < OP_COUNT) begin
      np = pops_of(op);
      nu = pushes_of(op);
      base = sp - np;
      if (sp < np) r.status = ST_UNDER;
      else if (base + nu > STACK_BYTES) r.status = ST_OVER;
      else begin
        if (np >= 1) tb = stk[sp-1];
        if (np >= 2) nb = stk[sp-2];
        if (np >= 4) t = word_below(sp);
        if (np >= 8) n = word_below(sp-4);
        if (op == OP_STORE) nb = stk[sp-5];
        case (op)
          OP_STORE, OP_LOAD: if (64'(t) + 1 > MEM_BYTES) r.status = ST_RANGE;
          OP_LOAD32, OP_STORE32: if (64'(t) + 4 > MEM_BYTES) r.status = ST_RANGE;
          OP_DIV8: if (nb == 0) r.status = ST_DIV0;
          OP_DIV32: if (n == 0) r.status = ST_DIV0;
          default: ;
        endcase
        if (r.status == ST_OK) begin
          case (op)
            OP_PUSH:    stk[base] = imm[7:0];
            OP_PUSH32:  put_word(base, imm);
            OP_POPA8:   ra = {24'd0, tb};
            OP_POPA32:  ra = t;
            OP_SUB8:    stk[base] = tb - nb;
            OP_ADD32:   put_word(base, t + n);
            OP_ADD8:    stk[base] = tb + nb;
            OP_SUB32:   put_word(base, t - n);
            OP_MUL8:    stk[base] = tb * nb;
            OP_MUL32:   put_word(base, t * n);
            OP_DIV8:    stk[base] = tb / nb;
            OP_DIV32:   put_word(base, t / n);
            OP_CMP:     stk[base] = order_code({24'd0, tb}, {24'd0, nb});
            OP_CMP32:   stk[base] = order_code(t, n);
            OP_SWAP8:   begin stk[base] = tb; stk[base+1] = nb; end
            OP_SWAP32:  begin put_word(base, t); put_word(base+4, n); end
            OP_PUTC:    begin r.char_valid = 1'b1; r.char_byte = tb; end
            OP_JE:      if (n == 1) r.next_pc = t;
            OP_JL:      if (n == 3) r.next_pc = t;
            OP_JG:      if (n == 2) r.next_pc = t;
            OP_JNE:     if (n != 1) r.next_pc = t;
            OP_JMP:     r.next_pc = t;
            OP_PUSHA32: put_word(base, ra);
            OP_PUSHA8:  stk[base] = ra[7:0];
            OP_DUP32:   begin put_word(base, t); put_word(base+4, t); end
            OP_DUP8:    begin stk[base] = tb; stk[base+1] = tb; end
            OP_POPB8:   rb = {24'd0, tb};
            OP_POPB32:  rb = t;
            OP_PUSHB32: put_word(base, rb);
            OP_PUSHB8:  stk[base] = rb[7:0];
            OP_MK4:     for (int i = 0; i < 3; i++) stk[base+i] = 8'd0;
            OP_STORE:   mem[t] = nb;
            OP_LOAD:    stk[base] = mem[t];
            OP_LOAD32:  put_word(base, {mem[t+3], mem[t+2], mem[t+1], mem[t]});
            OP_STORE32: for (int i = 0; i < 4; i++) mem[t+i] = n[8*i +: 8];
            default: ;
          endcase
          sp = base + nu;
        end
      end
      if (r.status != ST_OK) begin
        faulted = 1'b1;
        r.next_pc = pc;
      end
    end
    pc = r.next_pc;
    r.reg_a = ra;
    r.reg_b = rb;
    return r;
  endfunction

  always @(posedge clk) begin
    step_result_t e;
    if (!rst_n) begin
      sp = 0; ra = '0; rb = '0; pc = '0; faulted = 1'b0;
      for (int i = 0; i < MEM_BYTES; i++) mem[i] = 8'd0;
      expected_steps.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_steps.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count++;
        end else begin
          e = expected_steps.pop_front();
          if (out_next_pc !== e.next_pc) begin
            $error("next_pc exp %h got %h", e.next_pc, out_next_pc); fail_count++;
          end
          if (out_char_valid !== e.char_valid) begin
            $error("char_valid exp %b got %b", e.char_valid, out_char_valid);
            fail_count++;
          end
          if (out_char_byte !== e.char_byte) begin
            $error("char_byte exp %h got %h", e.char_byte, out_char_byte); fail_count++;
          end
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); fail_count++;
          end
          if (out_reg_a_value !== e.reg_a) begin
            $error("reg_a_value exp %h got %h", e.reg_a, out_reg_a_value);
            fail_count++;
          end
          if (out_reg_b_value !== e.reg_b) begin
            $error("reg_b_value exp %h got %h", e.reg_b, out_reg_b_value);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_steps.push_back(execute_step(in_op, in_immediate));
    end
    pending_count = expected_steps.size();
    stack_depth = sp;
  end

  initial begin
    fail_count = 0; pending_count = 0; stack_depth = 0; faulted = 1'b0;
  end
endmodule

// ----- test/byte_stack_machine_step_tb.sv -----
// Testbench top: stimulus, reset, clock and verdict for the stack machine.
module byte_stack_machine_step_tb;
  import bsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_BYTES = 256;
  localparam int MEM_BYTES   = 4096;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [5:0]  in_op = '0;
  logic [31:0] in_immediate = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_next_pc;
  logic        out_char_valid;
  logic [7:0]  out_char_byte;
  logic [2:0]  out_status;
  logic [31:0] out_reg_a_value, out_reg_b_value;
  int          fail_count, pending_count, stack_depth;
  logic        faulted;
  logic        sending_done = 1'b0;
  int          sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_stack_machine_step #(.STACK_BYTES(STACK_BYTES), .MEM_BYTES(MEM_BYTES)) dut (.*);

  byte_stack_machine_step_checker #(.STACK_BYTES(STACK_BYTES), .MEM_BYTES(MEM_BYTES))
    checker_i (.*);

  // one instruction transfer: random gap, then hold until accepted;
  // with no gap valid stays high and the next payload follows directly
  task automatic send_instr(logic [5:0] op, logic [31:0] imm);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op <= op;
    in_immediate <= imm;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic push_word(logic [31:0] v);
    send_instr(OP_PUSH32, v);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  // random memory address, always in range, sometimes at the very top or near the bottom
  function automatic logic [31:0] pick_addr(int width);
    case ($urandom_range(0, 9))
      0: return MEM_BYTES - width;
      1: return $urandom_range(0, 15);
      default: return $urandom_range(0, MEM_BYTES - width);
    endcase
  endfunction

  // one well-formed instruction given current stack depth
  task automatic random_instr();
    logic [5:0] op;
    int need;
    op = 6'($urandom_range(0, 35));
    need = checker_i.pops_of(op);
    if (stack_depth > STACK_BYTES - 24) op = OP_MK1;
    else begin
      // prepare operands so the step succeeds
      case (op)
        OP_LOAD, OP_LOAD32: push_word(pick_addr(op == OP_LOAD ? 1 : 4));
        OP_STORE: begin
          send_instr(OP_PUSH, $urandom);
          push_word(pick_addr(1));
        end
        OP_STORE32: begin
          push_word($urandom);
          push_word(pick_addr(4));
        end
        OP_DIV8: begin
          send_instr(OP_PUSH, $urandom_range(1, 255));
          send_instr(OP_PUSH, $urandom);
        end
        OP_DIV32: begin
          push_word($urandom_range(0, 3) == 0 ? $urandom_range(1, 9) : $urandom | 1);
          push_word($urandom);
        end
        OP_JE, OP_JL, OP_JG, OP_JNE: begin
          push_word($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 3));
          push_word($urandom);
        end
        default:
          while (stack_depth + 0 < need) send_instr(OP_PUSH32, $urandom);
      endcase
    end
    send_instr(op, $urandom);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, a spread of opcodes and an undefined opcode
    send_instr(OP_PUSH, 32'h0000_00FF);
    send_instr(OP_PUSH, 32'hFFFF_FF00);
    send_instr(OP_DIV8, '0);
    push_word(32'hFFFF_FFFF);
    push_word(32'h0000_0000);
    send_instr(OP_CMP32, '0);
    send_instr(OP_POPA8, '0);
    push_word(32'h8000_0001);
    send_instr(OP_DUP32, '0);
    send_instr(OP_MUL32, '0);
    send_instr(OP_POPB32, '0);
    send_instr(6'd63, '0);
    push_word(MEM_BYTES - 4);
    send_instr(OP_LOAD32, '0);
    send_instr(OP_PUTC, '0);
    send_instr(OP_MK4, '0);
    push_word(32'hDEAD_BEEF);
    send_instr(OP_JMP, '0);
    drain();

    // random body; fault sticks, so errors are left for the tail
    for (int i = 0; sent < 1520 && !faulted; i++) begin
      random_instr();
      if (i == 200) drain();
    end
    // provoke one kind of error, then a few faulted steps
    if (!faulted) begin
      case ($urandom_range(0, 3))
        0: begin
          while (stack_depth > 0) send_instr(OP_POPA8, '0);
          send_instr(OP_POPA32, '0);
        end
        1: while (!faulted) push_word($urandom);
        2: begin
          push_word(MEM_BYTES - 3);
          send_instr(OP_LOAD32, '0);
        end
        default: begin
          push_word(32'd0);
          push_word($urandom);
          send_instr(OP_DIV32, '0);
        end
      endcase
    end
    for (int i = 0; i < 10; i++) send_instr(6'($urandom_range(0, 63)), $urandom);
    in_valid <= 1'b0;
    sending_done <= 1'b1;
  end

  // receiver stalls: random per result, with quiet stretches
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) < 20) hold = 0;
      else hold = $urandom_range(0, 5);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    wait (sending_done);
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("byte_stack_machine_step test passed");
    else $display("byte_stack_machine_step test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("byte_stack_machine_step test failed");
    $finish;
  end
endmodule
